/* design/tgeb_pkg.sv */
// ----------------------------------------------------------------------------
// tgeb_pkg
// Shared types and constants of the time gate event builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tgeb_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // field widths
   localparam int CHID_W   = 6;
   localparam int SLICE_W  = 59;
   localparam int OFFS_W   = 32;
   localparam int TIME_W   = 60;
   localparam int ENERGY_W = 24;
   localparam int AMP_W    = 16;
   localparam int BASE_W   = 16;
   localparam int PEAK_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int TIE_W    = 16;
   localparam int GATE_W   = 16;
   localparam int MAXCH_W  = 4;
   localparam int SLOTCH_W = 4;

   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 152;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register select is paddr[2]
   localparam logic REG_WINDOW      = 1'b0;
   localparam logic REG_MAX_CHANNEL = 1'b1;

   localparam logic [GATE_W-1:0]  GATE_RESET  = 16'd960;
   localparam logic [MAXCH_W-1:0] MAXCH_RESET = 4'd9;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;

   typedef logic [NUM_CHANNELS-1:0] mask_type;

   typedef struct packed {
      logic [PEAK_W-1:0]   peak_index;
      logic [BASE_W-1:0]   baseline;
      logic [AMP_W-1:0]    amplitude;
      logic [ENERGY_W-1:0] energy;
   } pulse_type;

   // one slot of the channel store
   typedef struct packed {
      logic [TIE_W-1:0] tie;
      pulse_type        pulse;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic [CH_W-1:0]    ch;
      logic [SLICE_W-1:0] slice_time;
      logic [OFFS_W-1:0]  offset_time;
      pulse_type          pulse;
   } hit_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_JUDGE,
      ST_DRAIN_RD,
      ST_DRAIN_LOAD,
      ST_START
   } state_type;

endpackage

`default_nettype wire

/* design/tgeb_ram.sv */
// ----------------------------------------------------------------------------
// tgeb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tgeb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                                          clock,
   input  wire                                          we,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  wire [WIDTH-1:0]                              wdata,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* design/time_gate_event_builder.sv */
// ----------------------------------------------------------------------------
// time_gate_event_builder
// Groups time-ordered detector hits into fixed-length time windows and emits
// one record per occupied channel when a window closes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | tvalid/tready      | tdata: one detector hit
//  rsp     | out | tvalid/tready      | tdata + tlast: one channel record
//  csr     | in  | APB psel/penable   | window length, channel limit
//
//  A hit that joins or opens an event passes through accept, time sum and
//  window compare; a dropped hit is only accepted. Closing an event reads
//  each occupied channel in a read state and a load state, set by the
//  registered read of the slot RAM, then opens the new event; rsp stalls hold the drain.
//  Reset clears event state and the occupied mask; the slot RAM is not
//  cleared since a slot is only read while its occupied bit is set.
// ----------------------------------------------------------------------------
`default_nettype none

module time_gate_event_builder
   import tgeb_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   // hit stream
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // channel_id, slice_time, offset_time, energy, amplitude, baseline,
   // peak_index, zero pad
   input  wire [REQ_DATA_W-1:0]    req_tdata,
   // record stream
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   // event_time, hit_total, slot_channel, slot_energy, slot_amplitude,
   // slot_baseline, slot_peak_index, time_in_event
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   output logic                    rsp_tlast,
   // configuration
   input  wire                     csr_psel,
   input  wire                     csr_penable,
   input  wire                     csr_pwrite,
   input  wire [CSR_ADDR_W-1:0]    csr_paddr,
   input  wire [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   localparam mask_type ONE_BIT = mask_type'(1);

   // ---------------------------------------------------------------- csr
   logic [GATE_W-1:0]  gate_ff;
   logic [MAXCH_W-1:0] maxch_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff  <= GATE_RESET;
         maxch_ff <= MAXCH_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_WINDOW:      gate_ff  <= csr_pwdata[GATE_W-1:0];
            REG_MAX_CHANNEL: maxch_ff <= csr_pwdata[MAXCH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_WINDOW:      csr_prdata = CSR_DATA_W'(gate_ff);
         REG_MAX_CHANNEL: csr_prdata = CSR_DATA_W'(maxch_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- input unpack
   logic [CHID_W-1:0] in_ch;
   hit_type           in_hit;
   logic              in_drop;

   assign in_ch   = req_tdata[5:0];
   // ch, slice_time, offset_time, then pulse: peak_index, baseline, amplitude, energy
   assign in_hit  = {CH_W'(in_ch),
                     req_tdata[64:6],
                     req_tdata[96:65],
                     req_tdata[160:153],
                     req_tdata[152:137],
                     req_tdata[136:121],
                     req_tdata[120:97]};
   assign in_drop = (in_ch > CHID_W'(maxch_ff)) ||
                    (7'(in_ch) >= 7'(NUM_CHANNELS));

   // ---------------------------------------------------------------- state
   state_type             state_ff, state_in;
   hit_type               hit_ff, hit_in;
   logic [TIME_W-1:0]     t_ff, t_in;
   logic [TIME_W-1:0]     start_ff, start_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   mask_type              mask_ff, mask_in;
   logic [CH_W-1:0]       rd_ch_ff, rd_ch_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [TIME_W-1:0]     out_time_ff, out_time_in;
   logic [COUNT_W-1:0]    out_count_ff, out_count_in;
   logic [CH_W-1:0]       out_ch_ff, out_ch_in;
   slot_type              out_slot_ff, out_slot_in;

   // slot RAM
   logic                  ram_we;
   logic [CH_W-1:0]       ram_raddr;
   slot_type              ram_wdata;
   logic [SLOT_W-1:0]     ram_rdata;

   tgeb_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (NUM_CHANNELS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (hit_ff.ch),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // window compare
   logic [TIME_W:0]  diff;
   logic             early;
   logic             joins;
   mask_type         hit_bit;

   assign diff    = {1'b0, t_ff} - {1'b0, start_ff};
   assign early   = diff[TIME_W];
   assign joins   = early || ((diff[TIME_W-1:TIE_W] == '0) && (diff[TIE_W-1:0] < gate_ff));
   assign hit_bit = ONE_BIT << hit_ff.ch;

   // lowest occupied channel
   logic [CH_W-1:0] low_ch;
   always_comb begin
      low_ch = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_ch = CH_W'(i);
         end
      end
   end

   logic out_free;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      hit_in       = hit_ff;
      t_in         = t_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      mask_in      = mask_ff;
      rd_ch_in     = rd_ch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      out_time_in  = out_time_ff;
      out_count_in = out_count_ff;
      out_ch_in    = out_ch_ff;
      out_slot_in  = out_slot_ff;
      ram_we          = 1'b0;
      ram_raddr       = low_ch;
      ram_wdata.pulse = hit_ff.pulse;
      ram_wdata.tie   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               hit_in = in_hit;
               if (!in_drop) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            t_in     = TIME_W'(hit_ff.slice_time) + TIME_W'(hit_ff.offset_time);
            state_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            if (joins) begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               ram_we        = 1'b1;
               ram_wdata.tie = early ? '0 : diff[TIE_W-1:0];
               mask_in       = mask_ff | hit_bit;
               state_in      = ST_IDLE;
            end else if (mask_ff == '0) begin
               // empty event closes silently
               start_in = t_ff;
               count_in = COUNT_W'(1);
               mask_in  = hit_bit;
               ram_we   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DRAIN_RD;
            end
         end
         ST_DRAIN_RD: begin
            if (out_free) begin
               rd_ch_in = low_ch;
               mask_in  = mask_ff & ~(ONE_BIT << low_ch);
               state_in = ST_DRAIN_LOAD;
            end
         end
         ST_DRAIN_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = (mask_ff == '0);
            out_time_in  = start_ff;
            out_count_in = count_ff;
            out_ch_in    = rd_ch_ff;
            out_slot_in  = slot_type'(ram_rdata);
            state_in     = (mask_ff == '0) ? ST_START : ST_DRAIN_RD;
         end
         ST_START: begin
            start_in = t_ff;
            count_in = COUNT_W'(1);
            mask_in  = hit_bit;
            ram_we   = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         count_ff     <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff       <= hit_in;
      t_ff         <= t_in;
      rd_ch_ff     <= rd_ch_in;
      rsp_last_ff  <= rsp_last_in;
      out_time_ff  <= out_time_in;
      out_count_ff <= out_count_in;
      out_ch_ff    <= out_ch_in;
      out_slot_ff  <= out_slot_in;
   end

   // ---------------------------------------------------------------- output pack
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {out_slot_ff.tie,
                        out_slot_ff.pulse.peak_index,
                        out_slot_ff.pulse.baseline,
                        out_slot_ff.pulse.amplitude,
                        out_slot_ff.pulse.energy,
                        SLOTCH_W'(out_ch_ff),
                        out_count_ff,
                        out_time_ff};

endmodule

`default_nettype wire
